// File: design/sckd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_pkg: shared definitions for the serial console key decoder
// Key codes, parser modes, action codes, register defaults and the byte to
// key mapping functions.
// ----------------------------------------------------------------------------
package sckd_pkg;

  // Default number of hold-table slots.
  localparam int unsigned SCKD_HOLD_SLOTS = 8;

  // Register reset values.
  localparam logic [15:0] HOLD_TIME_RESET      = 16'd150;
  localparam logic [15:0] ESCAPE_TIMEOUT_RESET = 16'd30;

  // Register indexes on the configuration port.
  localparam logic REG_HOLD_TIME      = 1'b0;
  localparam logic REG_ESCAPE_TIMEOUT = 1'b1;

  // Input action codes.
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_BUTTONS = 2'd2;

  // Parser modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_CSI    = 3'd2;
  localparam logic [2:0] MODE_RAW_DN = 3'd3;
  localparam logic [2:0] MODE_RAW_UP = 3'd4;

  // Console bytes with a special meaning.
  localparam logic [7:0] BYTE_RAW_PRESS   = 8'hF0;
  localparam logic [7:0] BYTE_RAW_RELEASE = 8'hF1;
  localparam logic [7:0] BYTE_ESC         = 8'h1B;
  localparam logic [7:0] BYTE_LBRACKET    = 8'h5B;
  localparam logic [7:0] BYTE_ARROW_UP    = 8'h41;
  localparam logic [7:0] BYTE_ARROW_DOWN  = 8'h42;
  localparam logic [7:0] BYTE_ARROW_RIGHT = 8'h43;
  localparam logic [7:0] BYTE_ARROW_LEFT  = 8'h44;

  // Game key codes.
  localparam logic [7:0] K_NONE      = 8'h00;
  localparam logic [7:0] K_ENTER     = 8'd13;
  localparam logic [7:0] K_ESCAPE    = 8'd27;
  localparam logic [7:0] K_BACKSPACE = 8'h7F;
  localparam logic [7:0] K_USE       = 8'hA2;
  localparam logic [7:0] K_FIRE      = 8'hA3;
  localparam logic [7:0] K_LEFT      = 8'hAC;
  localparam logic [7:0] K_UP        = 8'hAD;
  localparam logic [7:0] K_RIGHT     = 8'hAE;
  localparam logic [7:0] K_DOWN      = 8'hAF;

  // Maps an ASCII console byte to a game key code.
  function automatic logic [7:0] map_ascii(input logic [7:0] c);
    logic [7:0] key;
    case (c)
      8'h0D, 8'h0A:        key = K_ENTER;
      8'h1B:               key = K_ESCAPE;
      8'h20:               key = K_USE;
      8'h77, 8'h57:        key = K_UP;
      8'h73, 8'h53:        key = K_DOWN;
      8'h61, 8'h41:        key = K_LEFT;
      8'h64, 8'h44:        key = K_RIGHT;
      8'h66, 8'h46, 8'h06: key = K_FIRE;
      8'h7F, 8'h08:        key = K_BACKSPACE;
      default: begin
        // Remaining capitals fold to lower case; all else passes through.
        if (c >= 8'h41 && c <= 8'h5A) key = c + 8'h20;
        else                          key = c;
      end
    endcase
    return key;
  endfunction

  // Key code for each button bit, in bit order.
  function automatic logic [7:0] button_key(input logic [2:0] bit_idx);
    logic [7:0] key;
    case (bit_idx)
      3'd0:    key = K_UP;
      3'd1:    key = K_DOWN;
      3'd2:    key = K_LEFT;
      3'd3:    key = K_RIGHT;
      3'd4:    key = K_FIRE;
      3'd5:    key = K_USE;
      3'd6:    key = K_ENTER;
      default: key = K_ESCAPE;
    endcase
    return key;
  endfunction

endpackage

// File: design/serial_console_key_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_console_key_decoder: console bytes to key press/release events
// Parses console bytes, millisecond ticks and button samples and produces a
// run of key events per input beat, with a hold table for tapped keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an action (byte, tick or button sample) with its byte
//   and button fields. One beat is taken at a time; in_stall stays high until
//   every event of that beat has been moved toward the output.
//   Each input beat produces zero to nine output beats; the final one of a
//   run carries out_last_of_run. A beat that produces nothing just completes.
//   The hold-table scans visit one slot per cycle, except where the release
//   scan waits to place an event, and use a single shared 32-bit adder.
//   Events pass through a one-entry pending register and an output register;
//   when out_stall is high the sequencer waits at the next event it needs
//   to place, and a new input beat can be taken while the last event waits.
//   Reset clears the parser, the clock count, the hold table, the button
//   history and the registers to their defaults (150 ms hold, 30 ms escape).
//   The APB registers: 0x0 hold time, 0x4 escape timeout (16 bits each).
// ----------------------------------------------------------------------------
module serial_console_key_decoder #(
  parameter int unsigned HOLD_SLOTS = sckd_pkg::SCKD_HOLD_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_button_bits,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_press,
  output logic [7:0]  out_key_code,
  output logic        out_last_of_run,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SLOT_W = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HOLD_SLOTS - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_TAP_START = 4'd2;
  localparam logic [3:0] S_TAP_SCAN  = 4'd3;
  localparam logic [3:0] S_TAP_FILL  = 4'd4;
  localparam logic [3:0] S_TAP_DONE  = 4'd5;
  localparam logic [3:0] S_ESC_CHK   = 4'd6;
  localparam logic [3:0] S_REL_SCAN  = 4'd7;
  localparam logic [3:0] S_BTN_SCAN  = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  // Registers.
  logic [3:0]        state_r,      state_nxt;
  logic [1:0]        action_r,     action_nxt;
  logic [7:0]        byte_r,       byte_nxt;
  logic [7:0]        btn_now_r,    btn_now_nxt;
  logic [7:0]        btn_chg_r,    btn_chg_nxt;
  logic [2:0]        btn_idx_r,    btn_idx_nxt;
  logic [7:0]        prev_btn_r,   prev_btn_nxt;
  logic [2:0]        mode_r,       mode_nxt;
  logic [31:0]       millis_r,     millis_nxt;
  logic [31:0]       stamp_r,      stamp_nxt;
  logic [SLOT_W-1:0] idx_r,        idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_idx_r,   free_idx_nxt;
  logic [7:0]        tap_key_r,    tap_key_nxt;
  logic              second_r,     second_nxt;
  logic [7:0]        second_key_r, second_key_nxt;
  logic              ret_rel_r,    ret_rel_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              pend_press_r, pend_press_nxt;
  logic [7:0]        pend_key_r,   pend_key_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              out_press_r,  out_press_nxt;
  logic [7:0]        out_key_r,    out_key_nxt;
  logic              out_last_r,   out_last_nxt;
  logic [15:0]       hold_ms_r;
  logic [15:0]       esc_to_r;

  // Hold table: key per slot (zero is empty) and its release deadline.
  logic [7:0]  held_key_r  [HOLD_SLOTS];
  logic [31:0] deadline_r  [HOLD_SLOTS];

  // Table write controls.
  logic              key_we;
  logic [SLOT_W-1:0] key_widx;
  logic [7:0]        key_wdata;
  logic              dl_we;
  logic [SLOT_W-1:0] dl_widx;

  // Slot under the scan pointer.
  logic [7:0]  cur_key;
  logic [31:0] cur_deadline;

  // Shared adder.
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_res;

  // Event placement.
  logic emit_req;
  logic emit_press;
  logic [7:0] emit_key;
  logic out_free;
  logic emit_ok;
  logic emit_go;
  logic stall_step;
  logic flush_go;

  logic in_fire;
  logic cfg_write;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_write = psel && penable && pwrite;

  assign cur_key      = held_key_r[idx_r];
  assign cur_deadline = deadline_r[idx_r];

  // One adder serves deadline sums and the two time differences.
  always_comb begin
    alu_a   = millis_r;
    alu_b   = {16'd0, hold_ms_r};
    alu_sub = 1'b0;
    case (state_r)
      S_ESC_CHK: begin
        alu_b   = stamp_r;
        alu_sub = 1'b1;
      end
      S_REL_SCAN: begin
        alu_b   = cur_deadline;
        alu_sub = 1'b1;
      end
      default: begin
        alu_b   = {16'd0, hold_ms_r};
        alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};
  end

  // Event request of the current step.
  always_comb begin
    emit_req   = 1'b0;
    emit_press = 1'b1;
    emit_key   = byte_r;
    case (state_r)
      S_DECODE: begin
        if (action_r == sckd_pkg::ACT_BYTE &&
            (mode_r == sckd_pkg::MODE_RAW_DN || mode_r == sckd_pkg::MODE_RAW_UP)) begin
          emit_req   = 1'b1;
          emit_press = (mode_r == sckd_pkg::MODE_RAW_DN);
          emit_key   = byte_r;
        end
      end
      S_TAP_FILL: begin
        emit_req   = free_found_r;
        emit_press = 1'b1;
        emit_key   = tap_key_r;
      end
      S_REL_SCAN: begin
        emit_req   = (cur_key != sckd_pkg::K_NONE) && !alu_res[31];
        emit_press = 1'b0;
        emit_key   = cur_key;
      end
      S_BTN_SCAN: begin
        emit_req   = btn_chg_r[btn_idx_r];
        emit_press = btn_now_r[btn_idx_r];
        emit_key   = sckd_pkg::button_key(btn_idx_r);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign emit_ok    = !pend_valid_r || out_free;
  assign emit_go    = emit_req && emit_ok;
  assign stall_step = emit_req && !emit_ok;
  assign flush_go   = (state_r == S_FINISH) && pend_valid_r && out_free;

  // Pending event and output register. A new event pushes the pending one
  // out as a middle beat; the end of the run pushes it out as the last beat.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_press_nxt = pend_press_r;
    pend_key_nxt   = pend_key_r;
    out_press_nxt  = out_press_r;
    out_key_nxt    = out_key_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (emit_go) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_press_nxt = pend_press_r;
        out_key_nxt   = pend_key_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_press_nxt = emit_press;
      pend_key_nxt   = emit_key;
    end else if (flush_go) begin
      out_valid_nxt  = 1'b1;
      out_press_nxt  = pend_press_r;
      out_key_nxt    = pend_key_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    byte_nxt       = byte_r;
    btn_now_nxt    = btn_now_r;
    btn_chg_nxt    = btn_chg_r;
    btn_idx_nxt    = btn_idx_r;
    prev_btn_nxt   = prev_btn_r;
    mode_nxt       = mode_r;
    millis_nxt     = millis_r;
    stamp_nxt      = stamp_r;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    tap_key_nxt    = tap_key_r;
    second_nxt     = second_r;
    second_key_nxt = second_key_r;
    ret_rel_nxt    = ret_rel_r;
    key_we         = 1'b0;
    key_widx       = idx_r;
    key_wdata      = sckd_pkg::K_NONE;
    dl_we          = 1'b0;
    dl_widx        = idx_r;

    if (!stall_step) begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            action_nxt  = in_action;
            byte_nxt    = in_rx_byte;
            btn_now_nxt = in_button_bits;
            state_nxt   = S_DECODE;
          end
        end

        S_DECODE: begin
          second_nxt  = 1'b0;
          ret_rel_nxt = 1'b0;
          state_nxt   = S_FINISH;
          case (action_r)
            sckd_pkg::ACT_BYTE: begin
              case (mode_r)
                sckd_pkg::MODE_ESC: begin
                  if (byte_r == sckd_pkg::BYTE_LBRACKET) begin
                    mode_nxt = sckd_pkg::MODE_CSI;
                  end else begin
                    // Lone escape, then the byte itself.
                    mode_nxt       = sckd_pkg::MODE_IDLE;
                    tap_key_nxt    = sckd_pkg::K_ESCAPE;
                    second_nxt     = 1'b1;
                    second_key_nxt = sckd_pkg::map_ascii(byte_r);
                    state_nxt      = S_TAP_START;
                  end
                end
                sckd_pkg::MODE_CSI: begin
                  mode_nxt = sckd_pkg::MODE_IDLE;
                  if (byte_r == sckd_pkg::BYTE_ARROW_UP) begin
                    tap_key_nxt = sckd_pkg::K_UP;
                    state_nxt   = S_TAP_START;
                  end else if (byte_r == sckd_pkg::BYTE_ARROW_DOWN) begin
                    tap_key_nxt = sckd_pkg::K_DOWN;
                    state_nxt   = S_TAP_START;
                  end else if (byte_r == sckd_pkg::BYTE_ARROW_RIGHT) begin
                    tap_key_nxt = sckd_pkg::K_RIGHT;
                    state_nxt   = S_TAP_START;
                  end else if (byte_r == sckd_pkg::BYTE_ARROW_LEFT) begin
                    tap_key_nxt = sckd_pkg::K_LEFT;
                    state_nxt   = S_TAP_START;
                  end
                end
                sckd_pkg::MODE_RAW_DN, sckd_pkg::MODE_RAW_UP: begin
                  // The raw event itself is placed by the event request.
                  mode_nxt = sckd_pkg::MODE_IDLE;
                end
                default: begin
                  if (byte_r == sckd_pkg::BYTE_RAW_PRESS) begin
                    mode_nxt = sckd_pkg::MODE_RAW_DN;
                  end else if (byte_r == sckd_pkg::BYTE_RAW_RELEASE) begin
                    mode_nxt = sckd_pkg::MODE_RAW_UP;
                  end else if (byte_r == sckd_pkg::BYTE_ESC) begin
                    mode_nxt  = sckd_pkg::MODE_ESC;
                    stamp_nxt = millis_r;
                  end else begin
                    mode_nxt    = sckd_pkg::MODE_IDLE;
                    tap_key_nxt = sckd_pkg::map_ascii(byte_r);
                    state_nxt   = S_TAP_START;
                  end
                end
              endcase
            end
            sckd_pkg::ACT_TICK: begin
              millis_nxt = millis_r + 32'd1;
              state_nxt  = S_ESC_CHK;
            end
            sckd_pkg::ACT_BUTTONS: begin
              btn_chg_nxt  = btn_now_r ^ prev_btn_r;
              prev_btn_nxt = btn_now_r;
              btn_idx_nxt  = 3'd0;
              state_nxt    = S_BTN_SCAN;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end

        S_TAP_START: begin
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          if (tap_key_r == sckd_pkg::K_NONE) state_nxt = S_TAP_DONE;
          else                               state_nxt = S_TAP_SCAN;
        end

        // One slot per cycle: a match refreshes its deadline, otherwise the
        // first empty slot is remembered.
        S_TAP_SCAN: begin
          if (cur_key == tap_key_r) begin
            dl_we     = 1'b1;
            dl_widx   = idx_r;
            state_nxt = S_TAP_DONE;
          end else begin
            if (cur_key == sckd_pkg::K_NONE && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = idx_r;
            end
            if (idx_r == LAST_SLOT) state_nxt = S_TAP_FILL;
            else                    idx_nxt   = idx_r + SLOT_W'(1);
          end
        end

        // A new key takes the free slot; a full table drops the tap.
        S_TAP_FILL: begin
          if (free_found_r) begin
            key_we    = 1'b1;
            key_widx  = free_idx_r;
            key_wdata = tap_key_r;
            dl_we     = 1'b1;
            dl_widx   = free_idx_r;
          end
          state_nxt = S_TAP_DONE;
        end

        S_TAP_DONE: begin
          if (second_r) begin
            second_nxt  = 1'b0;
            tap_key_nxt = second_key_r;
            state_nxt   = S_TAP_START;
          end else if (ret_rel_r) begin
            idx_nxt   = '0;
            state_nxt = S_REL_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end

        // Escape timeout after the tick has advanced the clock count.
        S_ESC_CHK: begin
          idx_nxt = '0;
          if (mode_r == sckd_pkg::MODE_ESC && alu_res > {16'd0, esc_to_r}) begin
            mode_nxt    = sckd_pkg::MODE_IDLE;
            tap_key_nxt = sckd_pkg::K_ESCAPE;
            second_nxt  = 1'b0;
            ret_rel_nxt = 1'b1;
            state_nxt   = S_TAP_START;
          end else begin
            state_nxt = S_REL_SCAN;
          end
        end

        // Release every held slot whose deadline has been reached.
        S_REL_SCAN: begin
          if (emit_req) begin
            key_we    = 1'b1;
            key_widx  = idx_r;
            key_wdata = sckd_pkg::K_NONE;
          end
          if (idx_r == LAST_SLOT) state_nxt = S_FINISH;
          else                    idx_nxt   = idx_r + SLOT_W'(1);
        end

        S_BTN_SCAN: begin
          if (btn_idx_r == 3'd7) state_nxt   = S_FINISH;
          else                   btn_idx_nxt = btn_idx_r + 3'd1;
        end

        S_FINISH: begin
          if (!pend_valid_r || out_free) state_nxt = S_IDLE;
        end

        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= sckd_pkg::MODE_IDLE;
      millis_r     <= 32'd0;
      prev_btn_r   <= 8'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      second_r     <= 1'b0;
      ret_rel_r    <= 1'b0;
      free_found_r <= 1'b0;
      idx_r        <= '0;
      btn_idx_r    <= 3'd0;
      hold_ms_r    <= sckd_pkg::HOLD_TIME_RESET;
      esc_to_r     <= sckd_pkg::ESCAPE_TIMEOUT_RESET;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      millis_r     <= millis_nxt;
      prev_btn_r   <= prev_btn_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      second_r     <= second_nxt;
      ret_rel_r    <= ret_rel_nxt;
      free_found_r <= free_found_nxt;
      idx_r        <= idx_nxt;
      btn_idx_r    <= btn_idx_nxt;
      if (cfg_write) begin
        if (paddr[2] == sckd_pkg::REG_HOLD_TIME) hold_ms_r <= pwdata[15:0];
        else                                     esc_to_r  <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    byte_r       <= byte_nxt;
    btn_now_r    <= btn_now_nxt;
    btn_chg_r    <= btn_chg_nxt;
    stamp_r      <= stamp_nxt;
    free_idx_r   <= free_idx_nxt;
    tap_key_r    <= tap_key_nxt;
    second_key_r <= second_key_nxt;
    pend_press_r <= pend_press_nxt;
    pend_key_r   <= pend_key_nxt;
    out_press_r  <= out_press_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Hold-table keys: cleared by reset, zero marks an empty slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HOLD_SLOTS; i++) begin
        held_key_r[i] <= sckd_pkg::K_NONE;
      end
    end else if (key_we) begin
      held_key_r[key_widx] <= key_wdata;
    end
  end

  // Release deadlines: always written with the key before they are read.
  always_ff @(posedge clk) begin
    if (dl_we) deadline_r[dl_widx] <= alu_res;
  end

  // Ports.
  assign out_valid       = out_valid_r;
  assign out_is_press    = out_press_r;
  assign out_key_code    = out_key_r;
  assign out_last_of_run = out_last_r;
  assign pready          = 1'b1;
  assign prdata          = {16'd0, (paddr[2] == sckd_pkg::REG_HOLD_TIME) ? hold_ms_r : esc_to_r};

  // An accepted beat keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted beat");

  // No event is left pending once the sequencer is back at rest.
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending event left behind at the end of a run");

  // A middle beat on the output always has the rest of its run pending.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> pend_valid_r)
    else $error("run ended without a last beat");

endmodule

// File: verif/serial_console_key_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_console_key_decoder_tb: self-checking bench for the key decoder
// Feeds console bytes, millisecond ticks and button samples through the input
// channel, predicts every key event in the bench, and compares each output
// beat with the oldest prediction. Register settings change between phases,
// and the sender and the receiver idle at varying rates.
// ----------------------------------------------------------------------------
module serial_console_key_decoder_tb;
  import sckd_pkg::*;

  localparam int RESET_CYCLES  = 12;
  // Cycles with work pending but no beat moving before the run is abandoned.
  localparam int STALL_LIMIT   = 2000;
  // Longest beat (escape and a following byte, two hold-table scans) plus margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_EVENTS    = 9;
  localparam int REPORT_CAP    = 200;

  // Action code that the decoder ignores.
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // Register byte addresses.
  localparam logic [2:0] ADDR_HOLD_TIME      = {REG_HOLD_TIME, 2'b00};
  localparam logic [2:0] ADDR_ESCAPE_TIMEOUT = {REG_ESCAPE_TIMEOUT, 2'b00};

  // Key code of each button bit, bit 0 first.
  localparam logic [7:0] BUTTON_CODES [8] = '{
    K_UP, K_DOWN, K_LEFT, K_RIGHT, K_FIRE, K_USE, K_ENTER, K_ESCAPE
  };

  // Bytes that hit the named keys, so taps repeat and collide in the table.
  localparam logic [7:0] COMMON_BYTES [12] = '{
    "w", "a", "s", "d", "W", "f", " ", 8'h0D, 8'h0A, 8'h7F, 8'h08, 8'h06
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] button_bits;
  } beat_t;

  typedef struct packed {
    logic       is_press;
    logic [7:0] key_code;
    logic       last_of_run;
  } key_event_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action      = ACT_BYTE;
  logic [7:0]  in_rx_byte     = 8'h00;
  logic [7:0]  in_button_bits = 8'h00;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_is_press;
  logic [7:0]  out_key_code;
  logic        out_last_of_run;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = 3'd0;
  logic [31:0] pwdata         = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Bench copy of the decoder state and registers.
  logic [15:0] hold_ms;
  logic [15:0] esc_timeout_ms;
  logic [2:0]  mode;
  logic [31:0] now_ms;
  logic [31:0] esc_stamp_ms;
  logic [7:0]  held [SCKD_HOLD_SLOTS];
  logic [31:0] deadline [SCKD_HOLD_SLOTS];
  logic [7:0]  last_buttons;

  beat_t      pending_beats[$];
  key_event_t run_events[$];
  key_event_t expected_events[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int beats_pushed   = 0;
  int beats_taken    = 0;
  int counted_beats  = 0;
  int events_seen    = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;

  serial_console_key_decoder #(
    .HOLD_SLOTS(SCKD_HOLD_SLOTS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_rx_byte     (in_rx_byte),
    .in_button_bits (in_button_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_press   (out_is_press),
    .out_key_code   (out_key_code),
    .out_last_of_run(out_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_decoder_state();
    int i;
    hold_ms        = HOLD_TIME_RESET;
    esc_timeout_ms = ESCAPE_TIMEOUT_RESET;
    mode           = MODE_IDLE;
    now_ms         = 32'd0;
    esc_stamp_ms   = 32'd0;
    last_buttons   = 8'h00;
    for (i = 0; i < SCKD_HOLD_SLOTS; i++) begin
      held[i]     = K_NONE;
      deadline[i] = 32'd0;
    end
  endfunction

  // Events beyond the ninth of a beat are lost.
  function automatic void add_event(input logic press, input logic [7:0] key);
    key_event_t ev;
    if (run_events.size() < MAX_EVENTS) begin
      ev.is_press    = press;
      ev.key_code    = key;
      ev.last_of_run = 1'b0;
      run_events.push_back(ev);
    end
  endfunction

  // A tap presses a new key and holds it; a held key only gets a new deadline.
  function automatic void tap_key(input logic [7:0] key);
    int i;
    int open_slot;
    open_slot = -1;
    if (key == K_NONE) return;
    for (i = 0; i < SCKD_HOLD_SLOTS; i++) begin
      if (held[i] == key) begin
        deadline[i] = now_ms + 32'(hold_ms);
        return;
      end
      if (held[i] == K_NONE && open_slot < 0) open_slot = i;
    end
    // A full table drops the tap without an event.
    if (open_slot < 0) return;
    held[open_slot]     = key;
    deadline[open_slot] = now_ms + 32'(hold_ms);
    add_event(1'b1, key);
  endfunction

  function automatic logic [7:0] key_for_byte(input logic [7:0] c);
    logic [7:0] folded;
    folded = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    case (folded)
      8'h0D, 8'h0A: return K_ENTER;
      " ":          return K_USE;
      "w":          return K_UP;
      "s":          return K_DOWN;
      "a":          return K_LEFT;
      "d":          return K_RIGHT;
      "f", 8'h06:   return K_FIRE;
      8'h7F, 8'h08: return K_BACKSPACE;
      default:      return folded;
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    case (mode)
      MODE_ESC: begin
        if (c == BYTE_LBRACKET) begin
          mode = MODE_CSI;
        end else begin
          // Escape followed by anything else: Escape, then the byte itself.
          tap_key(K_ESCAPE);
          mode = MODE_IDLE;
          tap_key(key_for_byte(c));
        end
      end
      MODE_CSI: begin
        mode = MODE_IDLE;
        case (c)
          BYTE_ARROW_UP:    tap_key(K_UP);
          BYTE_ARROW_DOWN:  tap_key(K_DOWN);
          BYTE_ARROW_RIGHT: tap_key(K_RIGHT);
          BYTE_ARROW_LEFT:  tap_key(K_LEFT);
          default: ;
        endcase
      end
      MODE_RAW_DN, MODE_RAW_UP: begin
        // Raw events skip the hold table.
        add_event(mode == MODE_RAW_DN, c);
        mode = MODE_IDLE;
      end
      default: begin
        if (c == BYTE_RAW_PRESS) begin
          mode = MODE_RAW_DN;
        end else if (c == BYTE_RAW_RELEASE) begin
          mode = MODE_RAW_UP;
        end else if (c == BYTE_ESC) begin
          mode         = MODE_ESC;
          esc_stamp_ms = now_ms;
        end else begin
          mode = MODE_IDLE;
          tap_key(key_for_byte(c));
        end
      end
    endcase
  endfunction

  function automatic void decode_tick();
    int i;
    logic [31:0] since;
    now_ms = now_ms + 32'd1;
    if (mode == MODE_ESC && (now_ms - esc_stamp_ms) > 32'(esc_timeout_ms)) begin
      tap_key(K_ESCAPE);
      mode = MODE_IDLE;
    end
    // Release every slot whose deadline has come, in slot order.
    for (i = 0; i < SCKD_HOLD_SLOTS; i++) begin
      since = now_ms - deadline[i];
      if (held[i] != K_NONE && !since[31]) begin
        add_event(1'b0, held[i]);
        held[i] = K_NONE;
      end
    end
  endfunction

  function automatic void decode_beat(input beat_t b);
    int i;
    logic [7:0] changed;
    key_event_t ev;
    run_events.delete();
    case (b.action)
      ACT_BYTE: decode_byte(b.rx_byte);
      ACT_TICK: decode_tick();
      ACT_BUTTONS: begin
        changed = b.button_bits ^ last_buttons;
        for (i = 0; i < 8; i++)
          if (changed[i]) add_event(b.button_bits[i], BUTTON_CODES[i]);
        last_buttons = b.button_bits;
      end
      default: ;
    endcase
    for (i = 0; i < run_events.size(); i++) begin
      ev             = run_events[i];
      ev.last_of_run = (i == run_events.size() - 1);
      expected_events.push_back(ev);
    end
  endfunction

  // ---------------------------------------------------------------- driver

  // Presents queued beats; the beat on the wire is predicted when accepted.
  always @(posedge clk) begin : drive_beats
    beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_beat('{action: in_action, rx_byte: in_rx_byte, button_bits: in_button_bits});
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nb = pending_beats.pop_front();
          in_valid       <= 1'b1;
          in_action      <= nb.action;
          in_rx_byte     <= nb.rx_byte;
          in_button_bits <= nb.button_bits;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Checks each accepted output beat against the oldest expected event.
  always @(posedge clk) begin : check_events
    key_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event press=%0b key=%02h last=%0b",
                                  out_is_press, out_key_code, out_last_of_run));
      end else begin
        want = expected_events.pop_front();
        if (out_is_press !== want.is_press || out_key_code !== want.key_code ||
            out_last_of_run !== want.last_of_run)
          report_mismatch($sformatf("got press=%0b key=%02h last=%0b, want %0b/%02h/%0b",
                                    out_is_press, out_key_code, out_last_of_run,
                                    want.is_press, want.key_code, want.last_of_run));
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (beats_pushed == beats_taken && expected_events.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("serial_console_key_decoder_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- register port

  task automatic read_reg(input logic [2:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in the bench state and reads it back.
  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_HOLD_TIME) hold_ms = value;
    else                        esc_timeout_ms = value;
    reg_writes++;
    read_reg(addr, readback);
    if (readback[15:0] !== value)
      report_mismatch($sformatf("register %0h reads %04h, wrote %04h",
                                addr, readback[15:0], value));
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic void push_beat(input logic [1:0] action, input logic [7:0] rx_byte,
                                    input logic [7:0] button_bits);
    pending_beats.push_back('{action: action, rx_byte: rx_byte, button_bits: button_bits});
    beats_pushed++;
    if (action != ACT_IGNORED) counted_beats++;
  endfunction

  // Unused fields carry random values.
  function automatic void push_byte(input logic [7:0] c);
    push_beat(ACT_BYTE, c, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_tick();
    push_beat(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_buttons(input logic [7:0] bits);
    push_beat(ACT_BUTTONS, 8'($urandom_range(0, 255)), bits);
  endfunction

  function automatic logic [7:0] any_key_byte();
    if ($urandom_range(0, 1) == 0) return COMMON_BYTES[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed sequence with random content, or now and then noise.
  function automatic void queue_random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      push_byte(any_key_byte());
    end else if (pick < 60) begin
      repeat ($urandom_range(1, 3)) push_tick();
    end else if (pick < 70) begin
      push_byte(BYTE_ESC);
      push_byte(BYTE_LBRACKET);
      if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)));
      else                           push_byte(8'(BYTE_ARROW_UP + $urandom_range(0, 3)));
    end else if (pick < 78) begin
      push_byte($urandom_range(0, 1) ? BYTE_RAW_PRESS : BYTE_RAW_RELEASE);
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 83) begin
      push_byte(BYTE_ESC);
    end else if (pick < 88) begin
      push_byte(BYTE_ESC);
      push_byte(any_key_byte());
    end else if (pick < 96) begin
      push_buttons(8'($urandom_range(0, 255)));
    end else begin
      push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
  endfunction

  // Waits until every beat is taken and every event seen, then lets the
  // decoder finish any beat that produced nothing.
  task automatic wait_drained();
    while (beats_pushed != beats_taken || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] hold, input logic [15:0] esc_timeout,
                           input int send_pct, input int stall_pct, input int n);
    int target;
    wait_drained();
    write_reg(ADDR_HOLD_TIME, hold);
    write_reg(ADDR_ESCAPE_TIMEOUT, esc_timeout);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = counted_beats + n;
    while (counted_beats < target) queue_random_sequence();
  endtask

  initial begin : main
    logic [31:0] reg_value;
    clear_decoder_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers come out of reset at their defaults.
    read_reg(ADDR_HOLD_TIME, reg_value);
    if (reg_value[15:0] !== HOLD_TIME_RESET)
      report_mismatch($sformatf("hold time resets to %04h", reg_value[15:0]));
    read_reg(ADDR_ESCAPE_TIMEOUT, reg_value);
    if (reg_value[15:0] !== ESCAPE_TIMEOUT_RESET)
      report_mismatch($sformatf("escape timeout resets to %04h", reg_value[15:0]));

    // Directed beats with short timers and no idling.
    write_reg(ADDR_HOLD_TIME, 16'd3);
    write_reg(ADDR_ESCAPE_TIMEOUT, 16'd2);
    push_buttons(8'hFF);
    push_buttons(8'h00);
    push_buttons(8'hA5);
    push_byte("w");
    push_byte("W");
    push_byte(8'h0D);
    push_byte(8'h00);
    push_byte(BYTE_RAW_PRESS);
    push_byte(8'h00);
    push_byte(BYTE_RAW_RELEASE);
    push_byte(8'hFF);
    push_byte(BYTE_ESC);
    push_byte(BYTE_LBRACKET);
    push_byte(BYTE_ARROW_DOWN);
    push_byte(BYTE_ESC);
    push_byte(BYTE_LBRACKET);
    push_byte("Z");
    push_byte(BYTE_ESC);
    push_byte("x");
    push_beat(ACT_IGNORED, 8'hFF, 8'hFF);
    push_byte(BYTE_ESC);
    repeat (6) push_tick();

    // Random phases; the long timers come last since they leave keys held.
    run_phase(16'd5, 16'd3, 54, 0, 23);
    run_phase(16'd0, 16'd0, 0, 54, 23);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)), 25, 25, 23);
    run_phase(16'hFFFF, 16'hFFFF, 0, 0, 23);

    wait_drained();
    $display("%0d input beats (%0d register writes), %0d key events checked, %0d mismatches",
             beats_taken, reg_writes, events_seen, mismatches);
    $display("covered taps, raw pairs, arrows, escape timeouts and button samples");
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("serial_console_key_decoder_tb passed");
    end else begin
      $display("serial_console_key_decoder_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sckd_pkg.sv
design/serial_console_key_decoder.sv
verif/serial_console_key_decoder_tb.sv
